>>> hdl/assert_macros.svh
// Assertion macros shared by the fan tachometer meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hdl/ftrm_pkg.sv
// Shared types and constants of the fan tachometer meter.
`default_nettype none
package ftrm_pkg;

   localparam int TIME_W     = 32;
   localparam int PPM_W      = 8;
   localparam int RATE_W     = 32;
   localparam int SPEED_W    = 32;
   localparam int NUM_W      = RATE_W + PPM_W;   // clock rate times pulses
   localparam int DEN_W      = TIME_W + 1;       // twice the interval
   localparam int LIMIT_W    = RATE_W + 2;       // three times the clock rate
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_PULSES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE   = 1'd1;

   localparam logic ACT_EDGE  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   localparam logic [PPM_W-1:0]  PPM_RESET  = 8'd2;
   localparam logic [RATE_W-1:0] RATE_RESET = 32'd2000000;

   typedef enum logic {
      JOB_ZERO,
      JOB_DIVIDE
   } job_kind_type;

   typedef struct packed {
      job_kind_type     kind;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage
`default_nettype wire

>>> hdl/ftrm_if.sv
// Handshake channel interfaces: request, response and register write.
`default_nettype none
interface ftrm_req_if;
   import ftrm_pkg::*;
   logic              valid;
   logic              ready;
   logic              action;
   logic [TIME_W-1:0] timer_now;
   modport source (output valid, action, timer_now, input ready);
   modport sink   (input valid, action, timer_now, output ready);
endinterface

interface ftrm_rsp_if;
   import ftrm_pkg::*;
   logic               valid;
   logic               ready;
   logic [SPEED_W-1:0] speed_value;
   modport source (output valid, speed_value, input ready);
   modport sink   (input valid, speed_value, output ready);
endinterface

interface ftrm_csr_if;
   import ftrm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

>>> hdl/ftrm_front.sv
// Front end: registers, edge counting and capture, query classification.
`default_nettype none
`include "assert_macros.svh"
module ftrm_front (
   input  logic                      clock,
   input  logic                      reset,
   ftrm_req_if.sink                  req_if,
   ftrm_csr_if.sink                  csr_if,
   input  ftrm_pkg::queue_status_type q_status,
   output logic                      push,
   output ftrm_pkg::job_type         push_job
);
   import ftrm_pkg::*;

   logic [PPM_W-1:0]   ppm_ff, ppm_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [PPM_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [TIME_W-1:0]  intv_ff, intv_in;

   logic               accept;
   logic [PPM_W-1:0]   cnt_inc;
   logic               capture;
   logic [TIME_W-1:0]  age;
   logic [LIMIT_W-1:0] limit;
   logic               stale;

   assign csr_if.ready = 1'b1;
   assign req_if.ready = !q_status.full;
   assign accept       = req_if.valid && req_if.ready;

   assign cnt_inc = cnt_ff + PPM_W'(1);
   assign capture = (cnt_inc == ppm_ff);

   // wrapping age of the last capture against 3x the tick rate (exact)
   assign age   = req_if.timer_now - last_ff;
   assign limit = {2'b00, rate_ff} + {1'b0, rate_ff, 1'b0};
   assign stale = ({2'b00, age} >= limit);

   assign push          = accept && (req_if.action == ACT_QUERY);
   assign push_job.kind = ((intv_ff == '0) || stale) ? JOB_ZERO : JOB_DIVIDE;
   assign push_job.num  = {{PPM_W{1'b0}}, rate_ff} * {{RATE_W{1'b0}}, ppm_ff};
   assign push_job.den  = {intv_ff, 1'b0};

   always_comb begin
      ppm_in  = ppm_ff;
      rate_in = rate_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      intv_in = intv_ff;
      if (csr_if.valid && csr_if.ready) begin
         case (csr_if.index)
            CSR_PULSES: ppm_in  = csr_if.wdata[PPM_W-1:0];
            CSR_RATE:   rate_in = csr_if.wdata[RATE_W-1:0];
            default:    ;
         endcase
      end
      if (accept && (req_if.action == ACT_EDGE)) begin
         if (capture) begin
            cnt_in  = '0;
            intv_in = req_if.timer_now - last_ff;
            last_in = req_if.timer_now;
         end else begin
            cnt_in = cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff  <= PPM_RESET;
         rate_ff <= RATE_RESET;
         cnt_ff  <= '0;
         last_ff <= '0;
         intv_ff <= '0;
      end else begin
         ppm_ff  <= ppm_in;
         rate_ff <= rate_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
         intv_ff <= intv_in;
      end
   end

   `ASSERT_ALWAYS(a_capture_clears, clock, reset, (accept && (req_if.action == ACT_EDGE) && capture) |=> (cnt_ff == '0), "count not cleared after capture")

endmodule
`default_nettype wire

>>> hdl/ftrm_queue.sv
// Short FIFO of classified queries between front end and divider.
`default_nettype none
`include "assert_macros.svh"
module ftrm_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ftrm_pkg::job_type          push_job,
   input  logic                       pop,
   output ftrm_pkg::job_type          head,
   output ftrm_pkg::queue_status_type status
);
   import ftrm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head         = slot_ff[rd_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   `ASSERT_NEVER(a_no_overflow, clock, reset, push && status.full, "push into full queue")
   `ASSERT_NEVER(a_no_underflow, clock, reset, pop && status.empty, "pop from empty queue")

endmodule
`default_nettype wire

>>> hdl/ftrm_div.sv
// Back end: radix-2 restoring divider with saturation and result register.
`default_nettype none
`include "assert_macros.svh"
module ftrm_div (
   input  logic                       clock,
   input  logic                       reset,
   input  ftrm_pkg::queue_status_type q_status,
   input  ftrm_pkg::job_type          head,
   output logic                       pop,
   ftrm_rsp_if.source                 rsp_if
);
   import ftrm_pkg::*;

   localparam int STEP_W = $clog2(SPEED_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SPEED_W - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   state_type          state_ff, state_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [SPEED_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               out_valid_ff, out_valid_in;
   logic [SPEED_W-1:0] out_data_ff, out_data_in;

   logic [DEN_W:0]     rem_shift;
   logic [DEN_W:0]     rem_diff;
   logic               take;

   assign rem_shift = {rem_ff, quot_ff[SPEED_W-1]};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign take      = (rem_shift >= {1'b0, den_ff});

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.speed_value = out_data_ff;

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_data_in  = out_data_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (head.kind == JOB_ZERO) begin
                  quot_in  = '0;
                  state_in = ST_OUT;
               end else if (DEN_W'(head.num[NUM_W-1:SPEED_W]) >= head.den) begin
                  // quotient needs more than 32 bits
                  quot_in  = '1;
                  state_in = ST_OUT;
               end else begin
                  rem_in   = DEN_W'(head.num[NUM_W-1:SPEED_W]);
                  quot_in  = head.num[SPEED_W-1:0];
                  den_in   = head.den;
                  step_in  = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            rem_in  = take ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            quot_in = {quot_ff[SPEED_W-2:0], take};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_if.ready) begin
               out_valid_in = 1'b1;
               out_data_in  = quot_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         rem_ff       <= rem_in;
         den_ff       <= den_in;
         quot_ff      <= quot_in;
         step_ff      <= step_in;
         out_data_ff  <= out_data_in;
      end
   end

   `ASSERT_ALWAYS(a_run_ends, clock, reset, (state_ff == ST_RUN && step_ff == STEP_LAST) |=> (state_ff == ST_OUT), "divider did not finish after last step")

endmodule
`default_nettype wire

>>> hdl/fan_tach_rpm_meter.sv
// Top level of the one-channel fan tachometer speed meter.
// Usage:
//   req_if carries one word per event: action 0 is a tach falling edge, action 1 a
//   speed query; timer_now is the free-running 32-bit timer sampled with it.
//   csr_if writes register 0 (pulses per measure, 8 bits) or register 1 (timer ticks per
//   second); it is always ready. The user must write it only while idle; the block does not enforce it.
//   rsp_if returns one word per query: speed = rate * pulses / (2 * interval),
//   zero if no interval was captured or the capture is at least 3 s (in ticks) old,
//   saturated to 32 bits. Edges return nothing.
// Timing:
//   Edges are taken one per cycle while the query queue is not full and update the
//   capture state at once. A query is classified on acceptance and queued; the
//   divider resolves one bit per cycle, and further queries wait in the queue
//   while it works. Zero or saturated answers skip the divider's bit steps.
//   req_if.ready drops only while the query queue is full.
// Reset: clears count, capture time and interval, loads pulses 2 and rate
//   2000000, and empties queue and result register.
// Stall: a held result sits in the output register while the divider keeps
//   working on the next queued query.
`default_nettype none
module fan_tach_rpm_meter #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   ftrm_req_if.sink    req_if,
   ftrm_rsp_if.source  rsp_if,
   ftrm_csr_if.sink    csr_if
);
   import ftrm_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head;
   logic             push;
   logic             pop;

   // front end: config registers, edge capture, query classification
   ftrm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .q_status (q_status),
      .push     (push),
      .push_job (push_job)
   );

   // decouples acceptance from the multi-cycle divide
   ftrm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // back end: divide, saturate, hold result for the receiver
   ftrm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .head     (head),
      .pop      (pop),
      .rsp_if   (rsp_if)
   );

endmodule
`default_nettype wire

>>> bench/fan_tach_rpm_meter_test.sv
// Self-checking testbench of the fan tachometer speed meter: directed, wrap, stall, random.
`default_nettype none
module fan_tach_rpm_meter_test;
   import ftrm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Receiver hold-off length and end-of-phase settle time, in clock cycles.
   // Settle covers one full divide with some margin.
   localparam int LONG_HOLD    = 150;
   localparam int SETTLE_TICKS = 40;
   localparam int PHASE_WORDS  = 115;
   localparam int PHASE_COUNT  = 12;

   logic clock = 1'b0;
   logic reset;

   ftrm_req_if req_bus ();
   ftrm_rsp_if rsp_bus ();
   ftrm_csr_if csr_bus ();

   fan_tach_rpm_meter i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #2 clock = ~clock;

   // Shadow copy of the meter: registers and capture state.
   logic [PPM_W-1:0]   cfg_pulses;
   logic [RATE_W-1:0]  cfg_rate;
   logic [PPM_W-1:0]   tach_count;
   logic [TIME_W-1:0]  last_capture;
   logic [TIME_W-1:0]  capture_gap;

   // Speeds still owed by the block, oldest first.
   logic [SPEED_W-1:0] speed_expected[$];
   logic [SPEED_W-1:0] speed_want;

   // Stimulus-side timer and idling controls.
   logic [TIME_W-1:0]  tick;
   bit                 req_idle_on = 1'b1;
   bit                 rsp_idle_on = 1'b1;
   int                 hold_requests = 0;

   // Run statistics.
   int mismatch_count  = 0;
   int words_sent      = 0;
   int query_count     = 0;
   int capture_count   = 0;
   int zero_answers    = 0;
   int sat_answers     = 0;
   int speeds_checked  = 0;

   // Most gaps zero, many short, a few long.
   function automatic int pick_gap(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 60)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Speed the block must answer for a query at 'now', from the shadow state.
   // Age uses wrapping 32-bit time and the timeout is exact; the quotient is exact
   // and clamps at the 32-bit maximum.
   function automatic logic [SPEED_W-1:0] speed_for(input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]  age;
      logic [LIMIT_W-1:0] stale_limit;
      logic [NUM_W-1:0]   num;
      logic [NUM_W-1:0]   den;
      logic [NUM_W-1:0]   quo;
      age         = now - last_capture;
      stale_limit = cfg_rate * 3;
      if (capture_gap == '0 || age >= stale_limit)
         return '0;
      num = cfg_rate * cfg_pulses;
      den = {capture_gap, 1'b0};
      quo = num / den;
      if (quo > {{(NUM_W-SPEED_W){1'b0}}, {SPEED_W{1'b1}}})
         return '1;
      return quo[SPEED_W-1:0];
   endfunction

   // Applies one accepted word to the shadow state.
   task automatic track_word(input logic act, input logic [TIME_W-1:0] now);
      logic [SPEED_W-1:0] speed;
      words_sent++;
      if (act == ACT_EDGE) begin
         tach_count = tach_count + 1'b1;
         if (tach_count == cfg_pulses) begin
            capture_gap  = now - last_capture;
            last_capture = now;
            tach_count   = '0;
            capture_count++;
         end
      end else begin
         speed = speed_for(now);
         query_count++;
         if (speed == '0)
            zero_answers++;
         if (speed == '1)
            sat_answers++;
         speed_expected.push_back(speed);
      end
   endtask

   // Offers one word, waits for it to be taken, then idles a random gap.
   // Valid stays high across back-to-back words.
   task automatic send_word(input logic act, input logic [TIME_W-1:0] now);
      int gap;
      req_bus.valid     <= 1'b1;
      req_bus.action    <= act;
      req_bus.timer_now <= now;
      do
         @(posedge clock);
      while (!req_bus.ready);
      track_word(act, now);
      gap = pick_gap(req_idle_on);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed speed has come back, then
   // lets the divider settle.
   task automatic drain();
      req_bus.valid <= 1'b0;
      do
         @(posedge clock);
      while (speed_expected.size() != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= data;
      do
         @(posedge clock);
      while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_PULSES)
         cfg_pulses = data[PPM_W-1:0];
      else
         cfg_rate = data[RATE_W-1:0];
      @(posedge clock);
   endtask

   // Hand-picked words: reset defaults, no interval, the staleness edge,
   // timer wrap, saturation, a never-stale rate and a zero rate.
   task automatic test_directed();
      send_word(ACT_QUERY, 32'd0);              // no interval yet
      send_word(ACT_EDGE,  32'd100);
      send_word(ACT_EDGE,  32'd1100);           // capture at 1100
      send_word(ACT_QUERY, 32'd1200);
      send_word(ACT_QUERY, 32'd6001099);        // one tick short of stale
      send_word(ACT_QUERY, 32'd6001100);        // exactly stale
      send_word(ACT_EDGE,  32'hFFFF_FFF0);
      send_word(ACT_EDGE,  32'h0000_0010);      // interval across timer wrap
      send_word(ACT_QUERY, 32'h0000_0020);
      drain();
      // 3 x rate exceeds 32 bits: never stale, and a one-tick interval
      // overflows the quotient.
      write_reg(CSR_RATE,   32'hFFFF_FFFF);
      write_reg(CSR_PULSES, 32'd3);
      send_word(ACT_EDGE,  32'd500);
      send_word(ACT_EDGE,  32'd500);
      send_word(ACT_EDGE,  32'd500);
      send_word(ACT_EDGE,  32'd500);
      send_word(ACT_EDGE,  32'd500);
      send_word(ACT_EDGE,  32'd501);
      send_word(ACT_QUERY, 32'd501);
      send_word(ACT_QUERY, 32'hFFFF_FFFF);
      drain();
      // Zero clock rate: every query is stale.
      write_reg(CSR_RATE, 32'd0);
      send_word(ACT_QUERY, 32'd502);
      drain();
   endtask

   // Pulse count wrapping: a zero register captures when the 8-bit count wraps, and a
   // register lowered below the running count waits for the wrap.
   task automatic test_counter_wrap();
      write_reg(CSR_RATE,   32'd1000);
      write_reg(CSR_PULSES, 32'd0);
      tick = 32'd7000;
      for (int n = 0; n < 260; n++) begin
         tick = tick + $urandom_range(0, 3);
         send_word((n % 64 == 63) ? ACT_QUERY : ACT_EDGE, tick);
      end
      drain();
      write_reg(CSR_PULSES, 32'd10);
      for (int n = 0; n < 5; n++) begin
         tick = tick + $urandom_range(0, 3);
         send_word(ACT_EDGE, tick);
      end
      drain();
      write_reg(CSR_PULSES, 32'd3);
      for (int n = 0; n < 280; n++) begin
         tick = tick + $urandom_range(0, 3);
         send_word((n % 20 == 19) ? ACT_QUERY : ACT_EDGE, tick);
      end
      drain();
   endtask

   // Receiver holds off for a long stretch while queries keep coming, so the
   // query queue fills and the request side stalls; then the sender waits
   // for every answer before going on.
   task automatic test_backpressure();
      write_reg(CSR_RATE,   RATE_RESET);
      write_reg(CSR_PULSES, 32'd2);
      tick = tick + 32'd5;
      send_word(ACT_EDGE, tick);
      tick = tick + 32'd400;
      send_word(ACT_EDGE, tick);
      hold_requests++;
      for (int n = 0; n < 10; n++) begin
         tick = tick + $urandom_range(0, 50);
         send_word(ACT_QUERY, tick);
      end
      drain();
   endtask

   // Random phases, each with its own register setting. Words are mostly
   // plausible edge trains with queries mixed in; one in ten jumps the
   // timer to a random value.
   task automatic test_random();
      logic [PPM_W:0]    ppm_span;
      logic [TIME_W-1:0] step_max;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase == 0) begin
            write_reg(CSR_PULSES, 32'd1);
            write_reg(CSR_RATE,   32'd1);
         end else if (phase == 1) begin
            write_reg(CSR_PULSES, 32'd255);
            write_reg(CSR_RATE,   32'hFFFF_FFFF);
         end else begin
            case ($urandom_range(0, 7))
               0:       write_reg(CSR_PULSES, 32'd1);
               1:       write_reg(CSR_PULSES, 32'd2);
               2:       write_reg(CSR_PULSES, 32'd255);
               3:       write_reg(CSR_PULSES, $urandom_range(1, 255));
               default: write_reg(CSR_PULSES, $urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 4))
               0:       write_reg(CSR_RATE, 32'd1);
               1:       write_reg(CSR_RATE, RATE_RESET);
               2:       write_reg(CSR_RATE, $urandom_range(2, 5000));
               3:       write_reg(CSR_RATE, $urandom);
               default: write_reg(CSR_RATE, 32'hFFFF_FFFF);
            endcase
         end
         // one phase runs with no idling on either side
         req_idle_on = (phase != 2);
         rsp_idle_on = (phase != 2);
         // edges spaced so a capture spans up to about one second of ticks
         ppm_span = (cfg_pulses == '0) ? 9'd256 : {1'b0, cfg_pulses};
         step_max = cfg_rate / ppm_span;
         if (step_max == '0)
            step_max = 32'd1;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(0, 9) == 0)
               tick = $urandom;
            else
               tick = tick + $urandom_range(0, step_max);
            send_word(($urandom_range(0, 9) < 3) ? ACT_QUERY : ACT_EDGE, tick);
         end
         drain();
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin
      int stall_left;
      int hold_left;
      int hold_served;
      stall_left      = 0;
      hold_left       = 0;
      hold_served     = 0;
      rsp_bus.ready   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD - 1;
            rsp_bus.ready <= 1'b0;
         end else if (!rsp_idle_on) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(1'b1);
         end
      end
   end

   // Speed checker: every word taken on the result side against the oldest
   // owed speed.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (speed_expected.size() == 0) begin
            $display("%0t ns: speed word with none owed: expected none, actual %0d",
                     $time, rsp_bus.speed_value);
            mismatch_count++;
         end else begin
            speed_want = speed_expected.pop_front();
            speeds_checked++;
            if (rsp_bus.speed_value !== speed_want) begin
               $display("%0t ns: speed_value mismatch: expected %0d, actual %0d",
                        $time, speed_want, rsp_bus.speed_value);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #(20_000_000);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.action    = ACT_EDGE;
      req_bus.timer_now = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_PULSES;
      csr_bus.wdata     = '0;
      cfg_pulses        = PPM_RESET;
      cfg_rate          = RATE_RESET;
      tach_count        = '0;
      last_capture      = '0;
      capture_gap       = '0;
      tick              = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_counter_wrap();
      test_backpressure();
      test_random();
      drain();

      if (speed_expected.size() != 0) begin
         $display("%0t ns: %0d speed words never came", $time, speed_expected.size());
         mismatch_count++;
      end
      $display("Run: %0d words sent, %0d captures, %0d queries, %0d speeds checked",
               words_sent, capture_count, query_count, speeds_checked);
      $display("Answers: %0d zero (stale or no interval), %0d saturated",
               zero_answers, sat_answers);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
`default_nettype wire
